>>> hw/rtl/pru_pkg.sv
package pru_pkg;

  localparam int unsigned MaxWidthDefault = 1024;
  localparam int unsigned MaxScaleDefault = 16;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned ScaleRegW = 5;
  localparam int unsigned WidthRegW = 11;

  localparam logic [CfgIdxW-1:0] CFG_SCALE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_PAD   = 2'd1,
    KIND_DROP  = 2'd2
  } kind_e;

  typedef struct packed {
    logic  take;
    logic  op;
    logic  emit;
    kind_e kind;
    logic  row_end;
    logic  last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       replaying;
    logic       ends;
    logic [1:0] pad;
    logic       out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/pru_in_if.sv
interface pru_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output op, output red, output green, output blue,
                  input ready);
  modport sink (input valid, input op, input red, input green, input blue,
                output ready);
endinterface

>>> hw/rtl/pru_out_if.sv
interface pru_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       row_end;
  logic       last;

  modport source (output valid, output kind, output out_red, output out_green,
                  output out_blue, output row_end, output last, input ready);
  modport sink (input valid, input kind, input out_red, input out_green,
                input out_blue, input row_end, input last, output ready);
endinterface

>>> hw/rtl/pru_datapath.sv
module pru_datapath
  import pru_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MaxWidthDefault,
  parameter int unsigned MAX_SCALE = MaxScaleDefault,
  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned EffWW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned ScaleW = $clog2(MAX_SCALE + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [23:0]         in_rgb_i,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  output logic [ScaleW-1:0]   scale_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [1:0]          out_kind_o,
  output logic [23:0]         out_rgb_o,
  output logic                out_row_end_o,
  output logic                out_last_o
);

  logic [ScaleRegW-1:0] scale_q;
  logic [WidthRegW-1:0] width_q;
  logic [ColW-1:0]      column_q, column_d;
  logic [ScaleW-1:0]    pass_q, pass_d;
  logic                 replaying_q, replaying_d;
  logic [23:0]          line_q [MAX_WIDTH];
  logic [23:0]          pix_q;
  logic                 out_valid_q;
  logic [1:0]           out_kind_q;
  logic [23:0]          out_rgb_q;
  logic                 out_row_end_q;
  logic                 out_last_q;

  logic [ScaleW-1:0] scale_eff;
  logic [EffWW-1:0]  width_eff;
  logic              ends;
  logic [1:0]        prod;
  logic [1:0]        pad;
  logic              take_pixel;
  logic              take_tick;

  always_comb begin
    if (scale_q == '0) begin
      scale_eff = ScaleW'(1);
    end else if (32'(scale_q) > MAX_SCALE) begin
      scale_eff = ScaleW'(MAX_SCALE);
    end else begin
      scale_eff = ScaleW'(scale_q);
    end
    if (width_q == '0) begin
      width_eff = EffWW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      width_eff = EffWW'(MAX_WIDTH);
    end else begin
      width_eff = EffWW'(width_q);
    end
  end

  assign ends = (32'(column_q) + 32'd1) >= 32'(width_eff);
  assign prod = 2'(4'(2'(scale_eff)) * 4'(2'(width_eff)) * 4'd3);
  assign pad  = ends ? 2'(~prod + 2'd1) : 2'd0;

  assign take_pixel = cmd_i.take && (cmd_i.op == OP_PIXEL) && !replaying_q;
  assign take_tick  = cmd_i.take && (cmd_i.op == OP_TICK) && replaying_q;

  always_comb begin
    column_d    = column_q;
    pass_d      = pass_q;
    replaying_d = replaying_q;
    if (take_pixel || take_tick) begin
      column_d = ends ? '0 : ColW'(column_q + 1'b1);
    end
    if (take_pixel && ends && (scale_eff > ScaleW'(1))) begin
      replaying_d = 1'b1;
      pass_d      = '0;
    end
    if (take_tick && ends) begin
      if ((32'(pass_q) + 32'd2) >= 32'(scale_eff)) begin
        replaying_d = 1'b0;
        pass_d      = '0;
      end else begin
        pass_d = ScaleW'(pass_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q       <= ScaleRegW'(1);
      width_q       <= WidthRegW'(1);
      column_q      <= '0;
      pass_q        <= '0;
      replaying_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCALE: scale_q <= ScaleRegW'(cfg_data_i);
          CFG_WIDTH: width_q <= WidthRegW'(cfg_data_i);
          default: ;
        endcase
      end
      column_q    <= column_d;
      pass_q      <= pass_d;
      replaying_q <= replaying_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_pixel) begin
      line_q[column_q] <= in_rgb_i;
      pix_q            <= in_rgb_i;
    end else if (take_tick) begin
      pix_q <= line_q[column_q];
    end
    if (cmd_i.emit) begin
      out_kind_q    <= cmd_i.kind;
      out_rgb_q     <= (cmd_i.kind == KIND_PIXEL) ? pix_q : 24'd0;
      out_row_end_q <= cmd_i.row_end;
      out_last_q    <= cmd_i.last;
    end
  end

  assign status_o.replaying = replaying_q;
  assign status_o.ends      = ends;
  assign status_o.pad       = pad;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign scale_o            = scale_eff;

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_rgb_o     = out_rgb_q;
  assign out_row_end_o = out_row_end_q;
  assign out_last_o    = out_last_q;

endmodule

>>> hw/rtl/pru_controller.sv
module pru_controller
  import pru_pkg::*;
#(
  parameter int unsigned MAX_SCALE = MaxScaleDefault,
  localparam int unsigned ScaleW = $clog2(MAX_SCALE + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  input  dp_status_t        status_i,
  input  logic [ScaleW-1:0] scale_i,
  output ctrl_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIX,
    ST_PAD,
    ST_DROP
  } state_e;

  state_e            state_q;
  logic [ScaleW-1:0] cnt_q;
  logic [1:0]        pad_q;
  logic              ends_q;
  logic              take;
  logic              cnt_one;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_ready_o && in_valid_i;
  assign cnt_one    = (cnt_q == ScaleW'(1));

  always_comb begin
    cmd_o.take    = take;
    cmd_o.op      = in_op_i;
    cmd_o.emit    = 1'b0;
    cmd_o.kind    = KIND_PIXEL;
    cmd_o.row_end = 1'b0;
    cmd_o.last    = 1'b0;
    case (state_q)
      ST_PIX: begin
        cmd_o.emit    = status_i.out_free;
        cmd_o.row_end = ends_q && (pad_q == 2'd0) && cnt_one;
        cmd_o.last    = (pad_q == 2'd0) && cnt_one;
      end
      ST_PAD: begin
        cmd_o.emit    = status_i.out_free;
        cmd_o.kind    = KIND_PAD;
        cmd_o.row_end = (pad_q == 2'd1);
        cmd_o.last    = (pad_q == 2'd1);
      end
      ST_DROP: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.kind = KIND_DROP;
        cmd_o.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pad_q   <= '0;
      ends_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            cnt_q  <= scale_i;
            pad_q  <= status_i.pad;
            ends_q <= status_i.ends;
            if (in_op_i == OP_PIXEL && status_i.replaying) begin
              state_q <= ST_DROP;
            end else if (in_op_i == OP_PIXEL || status_i.replaying) begin
              state_q <= ST_PIX;
            end
          end
        end
        ST_PIX: begin
          if (status_i.out_free) begin
            if (cnt_one) begin
              state_q <= (pad_q == 2'd0) ? ST_IDLE : ST_PAD;
            end else begin
              cnt_q <= ScaleW'(cnt_q - 1'b1);
            end
          end
        end
        ST_PAD: begin
          if (status_i.out_free) begin
            pad_q <= 2'(pad_q - 2'd1);
            if (pad_q == 2'd1) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_DROP: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/pixel_replicate_upscaler_unit.sv
// Nearest-neighbor integer upscaler for 24-bit RGB rows.
// The in_i channel carries one item per transfer: op selects a new pixel or a
// replay tick. The out_o channel carries one result per transfer: a pixel, a
// zero pad byte or a drop notice, with row_end and last flags.
// Each pixel is sent scale_factor times, followed at the end of an output row
// by zero pad bytes that bring the row to a multiple of four bytes. After a
// full input row, each tick replays one pixel from the line buffer until the
// row has been sent scale_factor times in total.
// Configuration is to be written through cfg_we_i, cfg_idx_i and cfg_data_i
// only while the block is idle; the block itself does not enforce this.
// For an item that yields results, the controller leaves idle and then loads
// the first result into the output register that drives out_o. It emits one
// result per cycle while that register is free, and takes no new item until
// it is idle; a dropped pixel gives a drop notice and an ignored tick none.
// When the receiver stalls, the result is held in the output register and
// the controller waits. Reset clears the row position and the replay state
// and sets scale_q and width_q to 1; the line buffer is not cleared.
module pixel_replicate_upscaler_unit
  import pru_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MaxWidthDefault,
  parameter int unsigned MAX_SCALE = MaxScaleDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  pru_in_if.sink              in_i,
  pru_out_if.source           out_o
);

  localparam int unsigned ScaleW = $clog2(MAX_SCALE + 1);

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [ScaleW-1:0] scale;
  logic [23:0]       out_rgb;

  pru_controller #(
    .MAX_SCALE(MAX_SCALE)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_op_i   (in_i.op),
    .in_ready_o(in_i.ready),
    .status_i  (status),
    .scale_i   (scale),
    .cmd_o     (cmd)
  );

  pru_datapath #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_SCALE(MAX_SCALE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_rgb_i     ({in_i.red, in_i.green, in_i.blue}),
    .cmd_i        (cmd),
    .status_o     (status),
    .scale_o      (scale),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_kind_o   (out_o.kind),
    .out_rgb_o    (out_rgb),
    .out_row_end_o(out_o.row_end),
    .out_last_o   (out_o.last)
  );

  assign out_o.out_red   = out_rgb[23:16];
  assign out_o.out_green = out_rgb[15:8];
  assign out_o.out_blue  = out_rgb[7:0];

endmodule
